[hw/rtl/htk_pkg.sv]
// shared types and constants for the request head tokenizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package htk_pkg;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam int NUM_METHODS = 8;
   localparam int MAX_RESULTS = 3;

   typedef enum logic [2:0] {
      KIND_METHOD  = 3'd0,
      KIND_PATH    = 3'd1,
      KIND_KEY     = 3'd2,
      KIND_VALUE   = 3'd3,
      KIND_HDR_END = 3'd4,
      KIND_DONE    = 3'd5,
      KIND_ERROR   = 3'd6
   } kind_type;

   typedef enum logic [4:0] {
      PH_METHOD  = 5'b00001,
      PH_PATH    = 5'b00010,
      PH_VERSION = 5'b00100,
      PH_HEADERS = 5'b01000,
      PH_IDLE    = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      HOLD_NONE  = 2'd0,
      HOLD_CR    = 2'd1,
      HOLD_COLON = 2'd2
   } hold_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_out;
      logic [2:0] method_code;
   } result_type;

   // all results caused by one input byte, count is 1 to 3
   typedef struct packed {
      logic [1:0]                       count;
      result_type [MAX_RESULTS-1:0]     res;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // method names left-aligned, zero padded to seven characters
   function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] p);
      logic [55:0] word;
      case (m)
         3'd0:    word = {"GET", 32'h0};
         3'd1:    word = {"POST", 24'h0};
         3'd2:    word = {"PUT", 32'h0};
         3'd3:    word = {"DELETE", 8'h0};
         3'd4:    word = "CONNECT";
         3'd5:    word = "OPTIONS";
         3'd6:    word = {"TRACE", 16'h0};
         3'd7:    word = {"PATCH", 16'h0};
         default: word = '0;
      endcase
      return word[55 - 8*int'(p) -: 8];
   endfunction

   function automatic logic [2:0] method_len(input logic [2:0] m);
      case (m)
         3'd0:    return 3'd3;
         3'd1:    return 3'd4;
         3'd2:    return 3'd3;
         3'd3:    return 3'd6;
         3'd4:    return 3'd7;
         3'd5:    return 3'd7;
         3'd6:    return 3'd5;
         3'd7:    return 3'd5;
         default: return 3'd0;
      endcase
   endfunction

endpackage

[hw/rtl/htk_req_if.sv]
// input channel: one raw request byte per item
// no dependencies
`timescale 1ns / 1ps

interface htk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, data_byte, end_of_buffer, input ready);
   modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

[hw/rtl/htk_rsp_if.sv]
// result channel: one token result per item
// no dependencies
`timescale 1ns / 1ps

interface htk_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] byte_out;
   logic [2:0] method_code;
   logic       last;

   modport source (output valid, kind, byte_out, method_code, last, input ready);
   modport sink   (input valid, kind, byte_out, method_code, last, output ready);
endinterface

[hw/rtl/htk_front.sv]
// front stage: accepts bytes, runs the tokenizer state and builds result bundles
// depends on htk_pkg and htk_req_if
`timescale 1ns / 1ps

module htk_front
   import htk_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   htk_req_if.sink         req_ch,
   input  q_status_type    q_stat,
   output logic            push_valid,
   output bundle_type      push_bundle
);

   phase_type  phase_ff, phase_in;
   logic [7:0] cand_ff, cand_in;
   logic [2:0] pos_ff, pos_in;
   hold_type   held_ff, held_in;
   logic       key_done_ff, key_done_in;
   logic       line_empty_ff, line_empty_in;

   logic       accept;
   logic [7:0] b;
   logic       eob;
   bundle_type bun;

   assign req_ch.ready = !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.data_byte;
   assign eob          = req_ch.end_of_buffer;

   always_comb begin
      logic [1:0] cnt;
      logic       do_plain;
      logic [2:0] code;
      cnt           = 2'd0;
      do_plain      = 1'b0;
      code          = 3'd0;
      bun           = '0;
      phase_in      = phase_ff;
      cand_in       = cand_ff;
      pos_in        = pos_ff;
      held_in       = held_ff;
      key_done_in   = key_done_ff;
      line_empty_in = line_empty_ff;

      case (phase_ff)
         PH_METHOD: begin
            if (b == CH_SP) begin
               for (int m = 0; m < NUM_METHODS; m++) begin
                  if (method_len(3'(m)) != pos_ff) cand_in[m] = 1'b0;
               end
               for (int m = 0; m < NUM_METHODS; m++) begin
                  if (cand_in[m]) code = 3'(m);
               end
               if (cand_in != 8'h00 && (cand_in & (cand_in - 8'd1)) == 8'h00) begin
                  bun.res[cnt] = '{KIND_METHOD, 8'h00, code};
                  cnt          = cnt + 2'd1;
                  phase_in     = PH_PATH;
               end else begin
                  bun.res[cnt] = '{KIND_ERROR, 8'h00, 3'd0};
                  cnt          = cnt + 2'd1;
                  phase_in     = PH_IDLE;
               end
            end else begin
               for (int m = 0; m < NUM_METHODS; m++) begin
                  if (pos_ff >= method_len(3'(m)) || method_char(3'(m), pos_ff) != b)
                     cand_in[m] = 1'b0;
               end
               if (pos_ff != 3'd7) pos_in = pos_ff + 3'd1;
            end
         end
         PH_PATH: begin
            if (b == CH_SP) begin
               phase_in = PH_VERSION;
            end else begin
               bun.res[cnt] = '{KIND_PATH, b, 3'd0};
               cnt          = cnt + 2'd1;
            end
         end
         PH_VERSION: begin
            if (held_ff == HOLD_CR && b == CH_LF) begin
               held_in       = HOLD_NONE;
               phase_in      = PH_HEADERS;
               key_done_in   = 1'b0;
               line_empty_in = 1'b1;
            end else begin
               held_in = (b == CH_CR) ? HOLD_CR : HOLD_NONE;
            end
         end
         PH_HEADERS: begin
            do_plain = 1'b1;
            held_in  = HOLD_NONE;
            if (held_ff == HOLD_CR) begin
               if (b == CH_LF) begin
                  do_plain = 1'b0;
                  if (key_done_ff) begin
                     bun.res[cnt]  = '{KIND_HDR_END, 8'h00, 3'd0};
                     cnt           = cnt + 2'd1;
                     key_done_in   = 1'b0;
                     line_empty_in = 1'b1;
                  end else begin
                     bun.res[cnt] = '{KIND_DONE, 8'h00, 3'd0};
                     cnt          = cnt + 2'd1;
                     phase_in     = PH_IDLE;
                  end
               end else if (key_done_ff) begin
                  bun.res[cnt] = '{KIND_VALUE, CH_CR, 3'd0};
                  cnt          = cnt + 2'd1;
               end else begin
                  bun.res[cnt]  = '{KIND_KEY, CH_CR, 3'd0};
                  cnt           = cnt + 2'd1;
                  line_empty_in = 1'b0;
               end
            end else if (held_ff == HOLD_COLON) begin
               line_empty_in = 1'b0;
               if (b == CH_SP) begin
                  do_plain    = 1'b0;
                  key_done_in = 1'b1;
               end else begin
                  bun.res[cnt] = '{KIND_KEY, CH_COLON, 3'd0};
                  cnt          = cnt + 2'd1;
               end
            end
            // the current byte, after any held byte has been settled
            if (do_plain) begin
               if (!key_done_ff) begin
                  if (b == CH_COLON) begin
                     held_in = HOLD_COLON;
                  end else if (b == CH_CR && line_empty_in) begin
                     held_in = HOLD_CR;
                  end else begin
                     bun.res[cnt]  = '{KIND_KEY, b, 3'd0};
                     cnt           = cnt + 2'd1;
                     line_empty_in = 1'b0;
                  end
               end else if (b == CH_CR) begin
                  held_in = HOLD_CR;
               end else begin
                  bun.res[cnt] = '{KIND_VALUE, b, 3'd0};
                  cnt          = cnt + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase

      if (eob) begin
         if (phase_in != PH_IDLE) begin
            bun.res[cnt] = '{KIND_ERROR, 8'h00, 3'd0};
            cnt          = cnt + 2'd1;
         end
         phase_in      = PH_METHOD;
         cand_in       = 8'hFF;
         pos_in        = 3'd0;
         held_in       = HOLD_NONE;
         key_done_in   = 1'b0;
         line_empty_in = 1'b1;
      end
      bun.count = cnt;
   end

   assign push_valid  = accept && (bun.count != 2'd0);
   assign push_bundle = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_METHOD;
         cand_ff       <= 8'hFF;
         pos_ff        <= 3'd0;
         held_ff       <= HOLD_NONE;
         key_done_ff   <= 1'b0;
         line_empty_ff <= 1'b1;
      end else if (accept) begin
         phase_ff      <= phase_in;
         cand_ff       <= cand_in;
         pos_ff        <= pos_in;
         held_ff       <= held_in;
         key_done_ff   <= key_done_in;
         line_empty_ff <= line_empty_in;
      end
   end

endmodule

[hw/rtl/htk_queue.sv]
// bundle queue between the front and back stages
// depends on htk_pkg; depth must be a power of two, at least two
`timescale 1ns / 1ps

module htk_queue
   import htk_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  bundle_type   push_bundle,
   input  logic         pop,
   output bundle_type   head,
   output q_status_type q_stat
);

   localparam int AW = $clog2(DEPTH);

   bundle_type      store_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     level_ff, level_in;
   logic            do_pop;

   assign q_stat.full  = (level_ff == (AW+1)'(DEPTH));
   assign q_stat.empty = (level_ff == '0);
   assign head         = store_ff[rd_ptr_ff];
   assign do_pop       = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      level_in  = level_ff + (AW+1)'(push_valid) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         store_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

[hw/rtl/htk_back.sv]
// back stage: sends the results of each queued bundle one item at a time
// depends on htk_pkg and htk_rsp_if
`timescale 1ns / 1ps

module htk_back
   import htk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  bundle_type   head,
   input  q_status_type q_stat,
   output logic         pop,
   htk_rsp_if.source    rsp_ch
);

   logic [1:0] idx_ff, idx_in;
   result_type cur;
   logic       is_last;
   logic       take;

   assign cur     = head.res[idx_ff];
   assign is_last = (idx_ff == head.count - 2'd1);
   assign take    = rsp_ch.valid && rsp_ch.ready;
   assign pop     = take && is_last;

   assign rsp_ch.valid       = !q_stat.empty;
   assign rsp_ch.kind        = cur.kind;
   assign rsp_ch.byte_out    = cur.byte_out;
   assign rsp_ch.method_code = cur.method_code;
   assign rsp_ch.last        = is_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[hw/rtl/http_request_head_tokenizer_unit.sv]
// request head tokenizer: one request byte in, zero to three token results out
// the results of a byte are queued when it is accepted and sent after earlier ones
// throughput: one byte per cycle while each byte gives at most one result and
// rsp_ch is ready; a byte with several results holds the back stage's single
// result port while they go out; up to QUEUE_DEPTH bundles buffer the difference
// synchronous reset returns the tokenizer to the method state and empties the queue
`timescale 1ns / 1ps

module http_request_head_tokenizer_unit
   import htk_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   htk_req_if.sink    req_ch,
   htk_rsp_if.source  rsp_ch
);

   logic         push_valid;
   bundle_type   push_bundle;
   logic         pop;
   bundle_type   head;
   q_status_type q_stat;

   htk_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .q_stat      (q_stat),
      .push_valid  (push_valid),
      .push_bundle (push_bundle)
   );

   htk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .pop         (pop),
      .head        (head),
      .q_stat      (q_stat)
   );

   htk_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   // done and error always close the results of their byte
   a_final_kind_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.kind == KIND_DONE || rsp_ch.kind == KIND_ERROR))
         |-> rsp_ch.last)
      else $error("done or error result not marked last");

   // the results of one byte follow each other with no gap
   a_bundle_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=> rsp_ch.valid)
      else $error("gap inside the results of one byte");

   // nothing is pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_stat.full)
      else $error("result bundle pushed into full queue");

endmodule
